// ===== rtl/sliding_window_per_type_admission_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sliding-window per-type admission block
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_PER_TYPE_ADMISSION_TOP_DEFINES_SVH
`define SLIDING_WINDOW_PER_TYPE_ADMISSION_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SWPTA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition at one edge that implies a condition at the next edge.
`define SWPTA_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/swpta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpta_pkg
// Shared constants, types and helpers of the sliding-window admission block.
// ----------------------------------------------------------------------------
package swpta_pkg;

  localparam int unsigned WINDOW_MAX = 1024;
  localparam int unsigned TYPE_COUNT = 1024;

  localparam int unsigned TYPE_W    = 10;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned TOTAL_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned RING_AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned SLOT_AW = $clog2(TYPE_COUNT);

  // Result queue between the decision stage and the output channel.
  localparam int unsigned OQ_DEPTH = 3;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic [CFG_W-1:0] WINDOW_LEN_RST   = CFG_W'(1024);
  localparam logic [CFG_W-1:0] MAX_PER_TYPE_RST = CFG_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN   = 1'b0,
    REG_MAX_PER_TYPE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [TYPE_W-1:0] item_type;
    logic              kept;
  } ring_entry_t;

  // Count-table updates issued by the decision stage.
  typedef struct packed {
    logic               inc;
    logic               dec;
    logic [SLOT_AW-1:0] dec_slot;
  } count_upd_t;

  typedef struct packed {
    logic               discarded;
    logic [TOTAL_W-1:0] discard_total;
  } result_t;

  function automatic logic [SLOT_AW-1:0] to_slot(input logic [TYPE_W-1:0] t);
    return SLOT_AW'(t % TYPE_COUNT);
  endfunction

endpackage

// ===== rtl/swpta_item_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpta_item_if
// Valid/ready channel carrying one arriving item type.
// ----------------------------------------------------------------------------
interface swpta_item_if import swpta_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] item_type;

  modport source (output valid, output item_type, input ready);
  modport sink   (input valid, input item_type, output ready);
endinterface

// ===== rtl/swpta_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpta_result_if
// Valid/ready channel carrying the admission result of one arrival.
// ----------------------------------------------------------------------------
interface swpta_result_if import swpta_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               discarded;
  logic [TOTAL_W-1:0] discard_total;

  modport source (output valid, output discarded, output discard_total, input ready);
  modport sink   (input valid, input discarded, input discard_total, output ready);
endinterface

// ===== rtl/swpta_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpta_ring
// Ring of recent arrivals (type and kept mark) with write-to-read forwarding.
// ----------------------------------------------------------------------------
module swpta_ring import swpta_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [RING_AW-1:0] rd_addr_i,
  input  logic               wr_en_i,
  input  logic [RING_AW-1:0] wr_addr_i,
  input  ring_entry_t        wr_data_i,
  output ring_entry_t        rd_data_o
);

  ring_entry_t        mem [WINDOW_MAX];
  ring_entry_t        rd_q;
  logic [RING_AW-1:0] rd_addr_q;
  logic               lw_v_q;
  logic [RING_AW-1:0] lw_addr_q;
  ring_entry_t        lw_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q      <= mem[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
    if (wr_en_i) begin
      lw_addr_q <= wr_addr_i;
      lw_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_v_q <= 1'b0;
    end else if (wr_en_i) begin
      lw_v_q <= 1'b1;
    end
  end

  // A write on the same edge as the read is not seen by the array read,
  // so the most recent write is compared against the read address.
  assign rd_data_o = (lw_v_q && (lw_addr_q == rd_addr_q)) ? lw_data_q : rd_q;

endmodule

// ===== rtl/swpta_counts.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpta_counts
// Per-type kept count, held as two tallies: kept arrivals and kept leaves.
// ----------------------------------------------------------------------------
module swpta_counts import swpta_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  output logic               busy_o,
  input  logic               rd_en_i,
  input  logic [SLOT_AW-1:0] rd_slot_i,
  input  logic [SLOT_AW-1:0] s1_slot_i,
  output logic [CNT_W-1:0]   count_o,
  input  count_upd_t         upd_i
);

  // The live count is arrivals minus leaves modulo 2^CNT_W. It never exceeds
  // the window depth, so the difference is exact and never saturates. Each
  // tally takes one read-modify-write per cycle on its own write port.
  logic [CNT_W-1:0] arr_mem [TYPE_COUNT];
  logic [CNT_W-1:0] lv_mem  [TYPE_COUNT];

  logic               clr_q, clr_d;
  logic [SLOT_AW-1:0] clr_idx_q, clr_idx_d;

  logic [CNT_W-1:0]   arr_rd_q, lva_rd_q, lvb_rd_q;
  logic               arr_lw_v_q, lv_lw_v_q;
  logic [SLOT_AW-1:0] arr_lw_slot_q, lv_lw_slot_q;
  logic [CNT_W-1:0]   arr_lw_data_q, lv_lw_data_q;
  logic               s2_dec_q;
  logic [SLOT_AW-1:0] s2_slot_q;

  logic [CNT_W-1:0]   arr_cur, lva_cur, lvb_cur;
  logic               lv_pend;
  logic               arr_we, lv_we;
  logic [SLOT_AW-1:0] arr_wslot, lv_wslot;
  logic [CNT_W-1:0]   arr_wdata, lv_wdata;

  always_comb begin
    arr_cur = (arr_lw_v_q && (arr_lw_slot_q == s1_slot_i)) ? arr_lw_data_q : arr_rd_q;
    lva_cur = (lv_lw_v_q && (lv_lw_slot_q == s1_slot_i)) ? lv_lw_data_q : lva_rd_q;
    // The leave still in flight is not yet written to the leave tally when this count is read.
    lv_pend = s2_dec_q && (s2_slot_q == s1_slot_i);
    count_o = arr_cur - lva_cur - CNT_W'(lv_pend);

    lvb_cur = (lv_lw_v_q && (lv_lw_slot_q == s2_slot_q)) ? lv_lw_data_q : lvb_rd_q;

    arr_we    = clr_q || upd_i.inc;
    arr_wslot = clr_q ? clr_idx_q : s1_slot_i;
    arr_wdata = clr_q ? '0 : arr_cur + CNT_W'(1);
    lv_we     = clr_q || s2_dec_q;
    lv_wslot  = clr_q ? clr_idx_q : s2_slot_q;
    lv_wdata  = clr_q ? '0 : lvb_cur + CNT_W'(1);

    clr_d     = clr_q;
    clr_idx_d = clr_idx_q;
    if (clr_q) begin
      clr_idx_d = clr_idx_q + SLOT_AW'(1);
      if (clr_idx_q == SLOT_AW'(TYPE_COUNT - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  assign busy_o = clr_q;

  always_ff @(posedge clk_i) begin
    if (arr_we) begin
      arr_mem[arr_wslot] <= arr_wdata;
      arr_lw_slot_q      <= arr_wslot;
      arr_lw_data_q      <= arr_wdata;
    end
    if (lv_we) begin
      lv_mem[lv_wslot] <= lv_wdata;
      lv_lw_slot_q     <= lv_wslot;
      lv_lw_data_q     <= lv_wdata;
    end
    if (rd_en_i) begin
      arr_rd_q <= arr_mem[rd_slot_i];
      lva_rd_q <= lv_mem[rd_slot_i];
    end
    if (upd_i.dec) begin
      lvb_rd_q <= lv_mem[upd_i.dec_slot];
    end
    s2_slot_q <= upd_i.dec_slot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_idx_q  <= '0;
      arr_lw_v_q <= 1'b0;
      lv_lw_v_q  <= 1'b0;
      s2_dec_q   <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      clr_idx_q <= clr_idx_d;
      if (arr_we) begin
        arr_lw_v_q <= 1'b1;
      end
      if (lv_we) begin
        lv_lw_v_q <= 1'b1;
      end
      s2_dec_q <= upd_i.dec;
    end
  end

endmodule

// ===== rtl/swpta_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpta_outq
// Small result queue that decouples the decision stage from the consumer.
// ----------------------------------------------------------------------------
module swpta_outq import swpta_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  result_t          push_data_i,
  output logic [OQ_CW-1:0] count_o,
  swpta_result_if.source   result_o
);

  result_t          entries_q [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [OQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [OQ_CW-1:0] cnt_q, cnt_d;
  logic             pop;

  always_comb begin
    pop      = result_o.valid && result_o.ready;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == OQ_AW'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + OQ_AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == OQ_AW'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + OQ_AW'(1);
    end
    cnt_d = cnt_q + OQ_CW'(push_i) - OQ_CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign count_o                = cnt_q;
  assign result_o.valid         = (cnt_q != '0);
  assign result_o.discarded     = entries_q[rd_ptr_q].discarded;
  assign result_o.discard_total = entries_q[rd_ptr_q].discard_total;

endmodule

// ===== rtl/sliding_window_per_type_admission_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_per_type_admission_top
// Admits or discards arrivals so that no type keeps more than max_per_type
// items within the last window_len arrivals.
// ----------------------------------------------------------------------------
// Usage: after reset the block clears its count tables, one entry per type,
// and holds item_i.ready low meanwhile; configuration writes are taken at
// any time. From then on it accepts one item per cycle while the result
// queue has room. An accepted item is registered into the decision stage,
// its result is pushed into the result queue and offered on result_o from
// there. That rate is set by the per-type count tables: each arrival does at
// most one read-modify-write on the kept-arrival tally and at most one on the
// leave tally, each a single-port write memory with forwarding, and by one
// ring read and one ring write per arrival. A three-entry result queue lets
// input acceptance continue while results wait on result_o.
// ----------------------------------------------------------------------------
`include "sliding_window_per_type_admission_top_defines.svh"

module sliding_window_per_type_admission_top import swpta_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  swpta_item_if.sink           item_i,
  swpta_result_if.source       result_o
);

  logic [CFG_W-1:0]   window_len_q, max_per_type_q;
  logic [RING_AW-1:0] wp_q, wp_d;
  logic [RING_AW-1:0] fill_q, fill_d;
  logic [TOTAL_W-1:0] disc_q, disc_d;

  logic               s1_v_q;
  logic [TYPE_W-1:0]  s1_type_q;
  logic [RING_AW-1:0] s1_wp_q;
  logic               s1_leave_q;
  logic               s1_self_q;

  logic               busy;
  logic               acc;
  logic [OQ_CW-1:0]   oq_cnt;
  logic [OQ_CW:0]     occ;
  logic [RING_AW-1:0] win_last;
  logic               leave;
  logic [RING_AW:0]   old_wide;
  logic [RING_AW-1:0] old_addr;
  logic [RING_AW-1:0] s1_wp_next;

  logic [CNT_W-1:0]   count;
  logic               drop;
  ring_entry_t        ring_rd;
  ring_entry_t        old_entry;
  ring_entry_t        ring_wdata;
  count_upd_t         upd;
  result_t            res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q   <= WINDOW_LEN_RST;
      max_per_type_q <= MAX_PER_TYPE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_WINDOW_LEN:   window_len_q   <= cfg_wdata_i;
        REG_MAX_PER_TYPE: max_per_type_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Accept side: window bookkeeping and the ring address of the leaving entry.
  always_comb begin
    occ         = (OQ_CW + 1)'(oq_cnt) + (OQ_CW + 1)'(s1_v_q);
    item_i.ready = !busy && (occ < (OQ_CW + 1)'(OQ_DEPTH));
    acc         = item_i.valid && item_i.ready;

    if (window_len_q == '0) begin
      win_last = '0;
    end else if (window_len_q > CFG_W'(WINDOW_MAX)) begin
      win_last = RING_AW'(WINDOW_MAX - 1);
    end else begin
      win_last = RING_AW'(window_len_q - CFG_W'(1));
    end
    // The fill level never shrinks, so a shortened window drains by one
    // entry per arrival only in the sense that it stops growing.
    leave = (fill_q >= win_last);

    if (wp_q >= fill_q) begin
      old_wide = (RING_AW + 1)'(wp_q) - (RING_AW + 1)'(fill_q);
    end else begin
      old_wide = (RING_AW + 1)'(wp_q) + (RING_AW + 1)'(WINDOW_MAX)
               - (RING_AW + 1)'(fill_q);
    end
    old_addr = old_wide[RING_AW-1:0];

    wp_d   = wp_q;
    fill_d = fill_q;
    if (acc) begin
      wp_d = (wp_q == RING_AW'(WINDOW_MAX - 1)) ? '0 : wp_q + RING_AW'(1);
      if (!leave) begin
        fill_d = fill_q + RING_AW'(1);
      end
    end
  end

  // Decision stage.
  always_comb begin
    drop = (count >= max_per_type_q);

    // With an empty history and a one-entry (or zero-length) window the arrival leaves at once.
    if (s1_self_q) begin
      old_entry.item_type = s1_type_q;
      old_entry.kept      = !drop;
    end else begin
      old_entry = ring_rd;
    end

    upd.inc      = s1_v_q && !drop;
    upd.dec      = s1_v_q && s1_leave_q && old_entry.kept;
    upd.dec_slot = to_slot(old_entry.item_type);

    ring_wdata.item_type = s1_type_q;
    ring_wdata.kept      = !drop;

    disc_d = disc_q;
    if (s1_v_q && drop && (disc_q != '1)) begin
      disc_d = disc_q + TOTAL_W'(1);
    end

    res.discarded     = drop;
    res.discard_total = disc_d;

    s1_wp_next = (s1_wp_q == RING_AW'(WINDOW_MAX - 1)) ? '0 : s1_wp_q + RING_AW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_type_q  <= item_i.item_type;
      s1_wp_q    <= wp_q;
      s1_leave_q <= leave;
      s1_self_q  <= leave && (fill_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      disc_q <= '0;
      s1_v_q <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      disc_q <= disc_d;
      s1_v_q <= acc;
    end
  end

  swpta_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (acc),
    .rd_addr_i (old_addr),
    .wr_en_i   (s1_v_q),
    .wr_addr_i (s1_wp_q),
    .wr_data_i (ring_wdata),
    .rd_data_o (ring_rd)
  );

  swpta_counts u_counts (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .busy_o    (busy),
    .rd_en_i   (acc),
    .rd_slot_i (to_slot(item_i.item_type)),
    .s1_slot_i (to_slot(s1_type_q)),
    .count_o   (count),
    .upd_i     (upd)
  );

  swpta_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_v_q),
    .push_data_i (res),
    .count_o     (oq_cnt),
    .result_o    (result_o)
  );

  `SWPTA_ASSERT(a_no_accept_while_clearing, busy |-> !(item_i.valid && item_i.ready), "item accepted during count table clear")
  `SWPTA_ASSERT(a_result_credit, occ <= (OQ_CW + 1)'(OQ_DEPTH), "result queue credit exceeded")
  `SWPTA_ASSERT(a_ring_slot_order, s1_v_q |-> (wp_q == s1_wp_next), "decision stage ring slot out of order")
  `SWPTA_ASSERT_NEXT(a_accept_reaches_decision, acc, s1_v_q, "accepted item missing from decision stage")

endmodule
